FILE: rtl/mst_pkg.sv
`timescale 1ns / 1ps
package mst_pkg;

   localparam int MAX_VERTICES = 16;
   localparam int MAX_EDGES    = 128;
   localparam int VTX_W        = 4;
   localparam int VCNT_W       = 5;
   localparam int EDGE_AW      = $clog2(MAX_EDGES);
   localparam int CNT_W        = $clog2(MAX_EDGES + 1);
   localparam int WGT_W        = 16;
   localparam int COST_W       = 20;

   typedef struct packed {
      logic [VTX_W-1:0]        a;
      logic [VTX_W-1:0]        b;
      logic signed [WGT_W-1:0] w;
   } mst_edge_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_NEXT,
      ST_SCAN,
      ST_PICK,
      ST_FIND_A,
      ST_FIND_B,
      ST_JOIN,
      ST_FLUSH
   } mst_state_type;

   typedef struct packed {
      logic load_ready;
      logic run_init;
      logic scan_init;
      logic scan_run;
      logic pick;
      logic find_a;
      logic find_b;
      logic join_edge;
      logic flush;
   } mst_cmd_type;

   typedef struct packed {
      logic load_last;
      logic scan_done;
      logic best_found;
      logic best_in_range;
      logic at_root;
      logic same_root;
      logic pend_valid;
      logic out_free;
      logic tree_full;
   } mst_sts_type;

endpackage

FILE: rtl/mst_ifs.sv
`timescale 1ns / 1ps
interface mst_req_if;
   logic                valid;
   logic                ready;
   logic [3:0]          row;
   logic [3:0]          col;
   logic signed [15:0]  weight;
   logic                last;
   modport source (output valid, row, col, weight, last, input ready);
   modport sink   (input valid, row, col, weight, last, output ready);
endinterface

interface mst_rsp_if;
   logic                valid;
   logic                ready;
   logic [3:0]          edge_from;
   logic [3:0]          edge_to;
   logic signed [15:0]  edge_weight;
   logic signed [19:0]  total_cost;
   logic                empty_res;
   logic                overflow;
   logic                final_res;
   modport source (output valid, edge_from, edge_to, edge_weight, total_cost,
                   empty_res, overflow, final_res, input ready);
   modport sink   (input valid, edge_from, edge_to, edge_weight, total_cost,
                   empty_res, overflow, final_res, output ready);
endinterface

interface mst_csr_if;
   logic       valid;
   logic       ready;
   logic [4:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/mst_ctrl.sv
`timescale 1ns / 1ps
module mst_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  mst_pkg::mst_sts_type sts,
   output mst_pkg::mst_cmd_type cmd
);
   import mst_pkg::*;

   mst_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (sts.load_last) state_in = ST_START;
         ST_START:  state_in = ST_NEXT;
         ST_NEXT:   state_in = sts.tree_full ? ST_FLUSH : ST_SCAN;
         ST_SCAN:   if (sts.scan_done) state_in = ST_PICK;
         ST_PICK: begin
            if (!sts.best_found) state_in = ST_FLUSH;
            else if (!sts.best_in_range) state_in = ST_NEXT;
            else state_in = ST_FIND_A;
         end
         ST_FIND_A: if (sts.at_root) state_in = ST_FIND_B;
         ST_FIND_B: if (sts.at_root) state_in = ST_JOIN;
         ST_JOIN: begin
            if (sts.same_root || sts.out_free || !sts.pend_valid) state_in = ST_NEXT;
         end
         ST_FLUSH:  if (sts.out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE:   cmd.load_ready = 1'b1;
         ST_START:  cmd.run_init = 1'b1;
         ST_NEXT:   cmd.scan_init = !sts.tree_full;
         ST_SCAN:   cmd.scan_run = 1'b1;
         ST_PICK:   cmd.pick = sts.best_found;
         ST_FIND_A: cmd.find_a = 1'b1;
         ST_FIND_B: cmd.find_b = 1'b1;
         ST_JOIN:   cmd.join_edge = !sts.same_root && (sts.out_free || !sts.pend_valid);
         ST_FLUSH:  cmd.flush = sts.out_free;
         default:   cmd = '0;
      endcase
   end

`ifndef SYNTH
   a_flush_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && sts.out_free) |=> (state_ff == ST_IDLE))
      else $error("flush did not return to idle");
   a_pick_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PICK) |-> ($past(state_ff) == ST_SCAN))
      else $error("pick entered without a scan");
   a_join_find: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_JOIN && $past(state_ff) != ST_JOIN) |-> ($past(state_ff) == ST_FIND_B))
      else $error("join entered without root search");
`endif
endmodule

FILE: rtl/mst_dp.sv
`timescale 1ns / 1ps
module mst_dp (
   input  logic                 clock,
   input  logic                 reset,
   mst_req_if.sink              req_bus,
   mst_rsp_if.source            rsp_bus,
   mst_csr_if.sink              csr_bus,
   input  mst_pkg::mst_cmd_type cmd,
   output mst_pkg::mst_sts_type sts
);
   import mst_pkg::*;

   mst_edge_type mem [MAX_EDGES];

   logic [VCNT_W-1:0]        vcount_ff;
   logic [VCNT_W-1:0]        v_eff;
   logic [CNT_W-1:0]         count_ff, run_count_ff, addr_ff;
   logic                     drop_ff, run_drop_ff;
   mst_edge_type             rd_ff, best_ff;
   logic                     rd_vld_ff;
   logic [EDGE_AW-1:0]       rd_idx_ff, best_idx_ff, prev_idx_ff;
   logic                     found_ff, have_prev_ff;
   logic signed [WGT_W-1:0]  prev_w_ff;
   logic [VTX_W-1:0]         parent_ff [MAX_VERTICES];
   logic [VTX_W-1:0]         cur_ff, rx_ff, par_cur;
   logic [VCNT_W-1:0]        taken_ff;
   logic signed [COST_W-1:0] total_ff, total_in;
   logic signed [COST_W:0]   sum_wide;
   logic                     pend_vld_ff;
   mst_edge_type             pend_ff;
   logic signed [COST_W-1:0] pend_tot_ff;
   logic                     accept, store_ok, is_gt, is_lt;
   logic                     out_vld_ff, out_empty_ff, out_ovf_ff, out_fin_ff;
   mst_edge_type             out_ff;
   logic signed [COST_W-1:0] out_tot_ff;

   always_comb begin
      v_eff = vcount_ff;
      if (vcount_ff == '0) v_eff = VCNT_W'(1);
      if (vcount_ff > VCNT_W'(MAX_VERTICES)) v_eff = VCNT_W'(MAX_VERTICES);
   end

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = cmd.load_ready;
   assign accept   = req_bus.valid && cmd.load_ready;
   assign store_ok = (req_bus.row < req_bus.col) && ({1'b0, req_bus.col} < v_eff)
                     && (req_bus.weight != '0);

   // ordered key compare: (weight, arrival index)
   assign is_gt = !have_prev_ff || (rd_ff.w > prev_w_ff)
                  || ((rd_ff.w == prev_w_ff) && (rd_idx_ff > prev_idx_ff));
   assign is_lt = !found_ff || (rd_ff.w < best_ff.w)
                  || ((rd_ff.w == best_ff.w) && (rd_idx_ff < best_idx_ff));

   assign par_cur  = parent_ff[cur_ff];
   assign sum_wide = COST_W'(0) + $signed({total_ff[COST_W-1], total_ff})
                     + $signed((COST_W+1)'(best_ff.w));

   always_comb begin
      if (sum_wide > $signed((COST_W+1)'(524287))) total_in = 20'sh7FFFF;
      else if (sum_wide < -$signed((COST_W+1)'(524288))) total_in = 20'sh80000;
      else total_in = sum_wide[COST_W-1:0];
   end

   always_comb begin
      sts.load_last     = accept && req_bus.last;
      sts.scan_done     = (addr_ff >= run_count_ff) && !rd_vld_ff;
      sts.best_found    = found_ff;
      sts.best_in_range = ({1'b0, best_ff.a} < v_eff) && ({1'b0, best_ff.b} < v_eff);
      sts.at_root       = (par_cur == cur_ff);
      sts.same_root     = (rx_ff == cur_ff);
      sts.pend_valid    = pend_vld_ff;
      sts.out_free      = !out_vld_ff || rsp_bus.ready;
      sts.tree_full     = (taken_ff + VCNT_W'(1)) >= v_eff;
   end

   // edge store
   always_ff @(posedge clock) begin
      if (accept && store_ok && (count_ff < CNT_W'(MAX_EDGES))) begin
         mem[count_ff[EDGE_AW-1:0]] <= '{a: req_bus.row, b: req_bus.col, w: req_bus.weight};
      end
      rd_ff <= mem[addr_ff[EDGE_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff   <= VCNT_W'(16);
         count_ff    <= '0;
         drop_ff     <= 1'b0;
         rd_vld_ff   <= 1'b0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
         found_ff    <= 1'b0;
         have_prev_ff <= 1'b0;
         addr_ff     <= '0;
         run_count_ff <= '0;
      end else begin
         if (csr_bus.valid) vcount_ff <= csr_bus.data;
         if (accept && store_ok) begin
            if (count_ff < CNT_W'(MAX_EDGES)) count_ff <= count_ff + CNT_W'(1);
            else drop_ff <= 1'b1;
         end
         if (cmd.run_init) begin
            run_count_ff <= count_ff;
            run_drop_ff  <= drop_ff;
            count_ff     <= '0;
            drop_ff      <= 1'b0;
            taken_ff     <= '0;
            total_ff     <= '0;
            pend_vld_ff  <= 1'b0;
            have_prev_ff <= 1'b0;
            for (int i = 0; i < MAX_VERTICES; i++) parent_ff[i] <= VTX_W'(i);
         end
         if (cmd.scan_init) begin
            addr_ff   <= '0;
            found_ff  <= 1'b0;
            rd_vld_ff <= 1'b0;
         end
         if (cmd.scan_run) begin
            rd_vld_ff <= addr_ff < run_count_ff;
            rd_idx_ff <= addr_ff[EDGE_AW-1:0];
            if (addr_ff < run_count_ff) addr_ff <= addr_ff + CNT_W'(1);
            if (rd_vld_ff && is_gt && is_lt) begin
               found_ff    <= 1'b1;
               best_ff     <= rd_ff;
               best_idx_ff <= rd_idx_ff;
            end
         end
         if (cmd.pick) begin
            have_prev_ff <= 1'b1;
            prev_w_ff    <= best_ff.w;
            prev_idx_ff  <= best_idx_ff;
            cur_ff       <= best_ff.a;
         end
         if (cmd.find_a) begin
            if (par_cur == cur_ff) begin
               rx_ff  <= cur_ff;
               cur_ff <= best_ff.b;
            end else begin
               cur_ff <= par_cur;
            end
         end
         if (cmd.find_b && (par_cur != cur_ff)) cur_ff <= par_cur;
         if (cmd.join_edge) begin
            parent_ff[rx_ff] <= cur_ff;
            taken_ff    <= taken_ff + VCNT_W'(1);
            total_ff    <= total_in;
            pend_vld_ff <= 1'b1;
            pend_ff     <= best_ff;
            pend_tot_ff <= total_in;
         end
         // result register
         if ((cmd.join_edge && pend_vld_ff) || cmd.flush) begin
            out_vld_ff   <= 1'b1;
            out_ovf_ff   <= run_drop_ff;
            out_fin_ff   <= cmd.flush;
            out_empty_ff <= cmd.flush && !pend_vld_ff;
            out_ff       <= pend_vld_ff ? pend_ff : '0;
            out_tot_ff   <= pend_vld_ff ? pend_tot_ff : '0;
            if (cmd.flush) pend_vld_ff <= 1'b0;
         end else if (rsp_bus.ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   assign rsp_bus.valid       = out_vld_ff;
   assign rsp_bus.edge_from   = out_ff.a;
   assign rsp_bus.edge_to     = out_ff.b;
   assign rsp_bus.edge_weight = out_ff.w;
   assign rsp_bus.total_cost  = out_tot_ff;
   assign rsp_bus.empty_res   = out_empty_ff;
   assign rsp_bus.overflow    = out_ovf_ff;
   assign rsp_bus.final_res   = out_fin_ff;

`ifndef SYNTH
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_EDGES))
      else $error("edge count beyond capacity");
   a_join_roots: assert property (@(posedge clock) disable iff (reset)
      cmd.join_edge |-> (rx_ff != cur_ff))
      else $error("join of two vertices with one root");
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.join_edge && pend_vld_ff) |-> (!out_vld_ff || rsp_bus.ready))
      else $error("result overwritten while stalled");
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_empty_ff) |-> (out_tot_ff == '0 && out_fin_ff))
      else $error("empty result carries data");
`endif
endmodule

FILE: rtl/minimum_spanning_tree_kruskal.sv
`timescale 1ns / 1ps
// Minimum spanning tree engine (Kruskal, union-find).
// Channels: req_bus takes adjacency-matrix words (row, col, weight, last),
// one word per cycle while the block is loading. Upper-triangle entries with
// nonzero weight and col below the vertex count are stored (up to 128 entries;
// further edges set the overflow flag of the run). rsp_bus returns tree edges
// with the running total cost; final_res marks the last word of a run, and a
// run without tree edges returns one word with empty_res set.
// csr_bus writes vertex_count (always ready); write it only while idle.
// After the word marked last, each candidate edge costs one scan of the edge
// store (one memory read per cycle), an advance and a pick step and, if both
// ends are in range, the root walks in the parent table (one hop per cycle)
// and a join step that waits while a held rsp word blocks its push. Req ready
// stays low from the word marked last until the final rsp word is registered.
// Throughput while loading: one matrix word per cycle.
// Reset: synchronous, active high; vertex_count returns to 16, the edge count
// and overflow flag clear, no result is pending. The store needs no clear.
// Stall: a held rsp word freezes the engine at its next push; nothing drops.
module minimum_spanning_tree_kruskal (
   input  logic      clock,
   input  logic      reset,
   mst_req_if.sink   req_bus,
   mst_rsp_if.source rsp_bus,
   mst_csr_if.sink   csr_bus
);
   import mst_pkg::*;

   mst_cmd_type cmd;
   mst_sts_type sts;

   // sequencer: load, scan for next edge, walk roots, join, emit
   mst_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   // store, parent table, cost and result register
   mst_dp u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus),
      .cmd     (cmd),
      .sts     (sts)
   );

endmodule

FILE: test/mst_checker.sv
`timescale 1ns / 1ps
module mst_checker (
   input  logic       clock,
   input  logic       reset,
   mst_req_if.sink    req_mon,
   mst_rsp_if.sink    rsp_mon,
   mst_csr_if.sink    csr_mon,
   output int         fail_count,
   output int         pending_edges
);
   import mst_pkg::*;

   typedef struct {
      logic [3:0]         from_v;
      logic [3:0]         to_v;
      logic signed [15:0] wgt;
      logic signed [19:0] cost;
      logic               empty_flag;
      logic               ovf_flag;
      logic               fin_flag;
   } tree_word_t;

   tree_word_t    tree_words_q[$];
   mst_edge_type  loaded_edges[$];
   logic [4:0]    vcount_reg;
   logic          dropped;

   assign pending_edges = tree_words_q.size();

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   function automatic int eff_count();
      if (vcount_reg == 0) return 1;
      if (vcount_reg > MAX_VERTICES) return MAX_VERTICES;
      return vcount_reg;
   endfunction

   function automatic int find_root(ref int par[MAX_VERTICES], input int x);
      int steps;
      steps = 0;
      while (par[x] != x && steps < MAX_VERTICES) begin
         x = par[x];
         steps++;
      end
      return x;
   endfunction

   // Build tree words for one run: stable sort, then Kruskal scan.
   task automatic predict_tree();
      mst_edge_type srt[$];
      int par[MAX_VERTICES];
      int v, taken, x, y, j, n0;
      int total;
      tree_word_t tw;
      mst_edge_type key;
      v = eff_count();
      taken = 0;
      total = 0;
      srt = loaded_edges;
      for (int i = 1; i < srt.size(); i++) begin
         key = srt[i];
         j = i;
         while (j > 0 && srt[j-1].w > key.w) begin
            srt[j] = srt[j-1];
            j--;
         end
         srt[j] = key;
      end
      for (int i = 0; i < MAX_VERTICES; i++) par[i] = i;
      n0 = tree_words_q.size();
      for (int i = 0; i < srt.size() && taken + 1 < v; i++) begin
         if (srt[i].a >= v || srt[i].b >= v) continue;
         x = find_root(par, srt[i].a);
         y = find_root(par, srt[i].b);
         if (x != y) begin
            total += srt[i].w;
            if (total > 524287) total = 524287;
            if (total < -524288) total = -524288;
            tw = '{srt[i].a, srt[i].b, srt[i].w, total[19:0], 1'b0, dropped, 1'b0};
            tree_words_q.push_back(tw);
            taken++;
            par[x] = y;
         end
      end
      if (tree_words_q.size() == n0) begin
         tw = '{4'd0, 4'd0, 16'sd0, 20'sd0, 1'b1, dropped, 1'b1};
         tree_words_q.push_back(tw);
      end else begin
         tree_words_q[$].fin_flag = 1'b1;
      end
      loaded_edges.delete();
      dropped = 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         vcount_reg <= 5'd16;
         dropped = 1'b0;
         loaded_edges.delete();
         tree_words_q.delete();
         fail_count = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) vcount_reg <= csr_mon.data;
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.row < req_mon.col && req_mon.col < eff_count()
                && req_mon.weight != 0) begin
               if (loaded_edges.size() < MAX_EDGES)
                  loaded_edges.push_back('{req_mon.row, req_mon.col, req_mon.weight});
               else
                  dropped = 1'b1;
            end
            if (req_mon.last) predict_tree();
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (tree_words_q.size() == 0) begin
               report_mismatch("unexpected result word");
            end else begin
               tree_word_t e;
               e = tree_words_q.pop_front();
               if (rsp_mon.edge_from !== e.from_v || rsp_mon.edge_to !== e.to_v
                   || rsp_mon.edge_weight !== e.wgt || rsp_mon.total_cost !== e.cost
                   || rsp_mon.empty_res !== e.empty_flag
                   || rsp_mon.overflow !== e.ovf_flag
                   || rsp_mon.final_res !== e.fin_flag)
                  report_mismatch($sformatf(
                     "got %0d-%0d w%0d c%0d e%b o%b f%b exp %0d-%0d w%0d c%0d e%b o%b f%b",
                     rsp_mon.edge_from, rsp_mon.edge_to, rsp_mon.edge_weight,
                     rsp_mon.total_cost, rsp_mon.empty_res, rsp_mon.overflow,
                     rsp_mon.final_res, e.from_v, e.to_v, e.wgt, e.cost,
                     e.empty_flag, e.ovf_flag, e.fin_flag));
            end
         end
      end
   end
endmodule

FILE: test/minimum_spanning_tree_kruskal_tb.sv
`timescale 1ns / 1ps
module minimum_spanning_tree_kruskal_tb;
   logic clock;
   logic reset;
   int   fail_count;
   int   pending_edges;
   int   cycle_count;
   bit   test_done;
   bit   req_held;

   mst_req_if req_bus ();
   mst_rsp_if rsp_bus ();
   mst_csr_if csr_bus ();

   minimum_spanning_tree_kruskal u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   mst_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus.sink),
      .rsp_mon       (rsp_bus.sink),
      .csr_mon       (csr_bus.sink),
      .fail_count    (fail_count),
      .pending_edges (pending_edges)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a slow run scans the store once per candidate edge, so allow plenty.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("minimum_spanning_tree_kruskal_tb: FAIL");
         $finish;
      end
   end

   // Result side: stall ready at random before each word.
   int rsp_stall;
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_bus.valid && rsp_bus.ready) begin
         // burst mode (no stall) in roughly a quarter of the time
         rsp_stall <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Drop valid once, if a word is still being presented.
   task automatic release_req();
      if (req_held) begin
         req_bus.valid <= 1'b0;
         req_held = 1'b0;
      end
   endtask

   // Send one word and hold it until the block takes it. Valid stays high
   // after the handshake so a following word with no gap goes out directly.
   task automatic send_word(input logic [3:0] r, input logic [3:0] c,
                            input logic signed [15:0] w, input logic l,
                            input int gap);
      if (gap > 0) release_req();
      repeat (gap) @(posedge clock);
      req_bus.valid  <= 1'b1;
      req_bus.row    <= r;
      req_bus.col    <= c;
      req_bus.weight <= w;
      req_bus.last   <= l;
      req_held = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Write vertex_count only once every tree word has drained.
   task automatic write_vcount(input logic [4:0] v);
      wait_idle();
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= v;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      release_req();
      @(posedge clock);
      while (pending_edges != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic int draw_gap();
      return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
   endfunction

   // Random graph: mostly valid upper-triangle edges, some noise entries.
   task automatic random_graph(input int n_entries, input int vmax);
      logic [3:0] r, c;
      logic signed [15:0] w;
      for (int i = 0; i < n_entries; i++) begin
         if ($urandom_range(0, 5) == 0) begin
            r = 4'($urandom);
            c = 4'($urandom);
         end else begin
            r = 4'($urandom_range(0, vmax - 2));
            c = 4'($urandom_range(r + 1, vmax - 1));
         end
         case ($urandom_range(0, 7))
            0:       w = 16'sd0;
            1:       w = 16'($urandom);
            2:       w = ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
            default: w = $signed(16'($urandom_range(0, 60))) - 16'sd20;
         endcase
         send_word(r, c, w, i == n_entries - 1, draw_gap());
      end
   endtask

   int words_sent;
   int vsel;

   initial begin
      reset          = 1'b1;
      cycle_count    = 0;
      req_held       = 1'b0;
      req_bus.valid  = 1'b0;
      req_bus.row    = '0;
      req_bus.col    = '0;
      req_bus.weight = '0;
      req_bus.last   = 1'b0;
      csr_bus.valid  = 1'b0;
      csr_bus.data   = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: lone last entry gives an empty tree.
      send_word(4'd0, 4'd0, 16'sd0, 1'b1, 0);
      // Extreme weights, ties, lower triangle and diagonal ignored.
      send_word(4'd0, 4'd15, 16'sh7fff, 1'b0, 0);
      send_word(4'd0, 4'd15, 16'sh8000, 1'b0, 0);
      send_word(4'd3, 4'd1, 16'sd5, 1'b0, 0);
      send_word(4'd7, 4'd7, 16'sd5, 1'b0, 1);
      send_word(4'd1, 4'd2, 16'sd5, 1'b0, 0);
      send_word(4'd2, 4'd3, 16'sd5, 1'b0, 0);
      send_word(4'd1, 4'd3, 16'sd5, 1'b0, 0);
      send_word(4'd14, 4'd15, -16'sd1, 1'b1, 0);
      // Count changed before the run: edges above 3 vertices are skipped.
      send_word(4'd0, 4'd1, 16'sd9, 1'b0, 0);
      send_word(4'd2, 4'd9, 16'sd1, 1'b0, 0);
      write_vcount(5'd3);
      send_word(4'd1, 4'd2, 16'sd4, 1'b1, 0);
      // Extremes of the register: 0 acts as 1, large saturates to 16.
      write_vcount(5'd0);
      send_word(4'd0, 4'd1, 16'sd3, 1'b1, 0);
      write_vcount(5'd31);
      send_word(4'd0, 4'd15, 16'sd3, 1'b1, 0);
      write_vcount(5'd16);
      // Store full: 130 entries, the last two dropped.
      for (int i = 0; i < 130; i++)
         send_word(4'($urandom_range(0, 7)), 4'($urandom_range(8, 15)),
                   16'($urandom_range(1, 500)), i == 129, 0);
      wait_idle();

      // Random phases across vertex counts.
      words_sent = 0;
      while (words_sent < 330) begin
         vsel = $urandom_range(0, 5);
         case (vsel)
            0:       write_vcount(5'd2);
            1:       write_vcount(5'd16);
            2:       write_vcount(5'($urandom_range(0, 31)));
            default: write_vcount(5'($urandom_range(3, 8)));
         endcase
         begin
            int n;
            n = $urandom_range(1, 30);
            random_graph(n, 16);
            words_sent += n;
         end
      end

      wait_idle();
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending_edges == 0)
         $display("minimum_spanning_tree_kruskal_tb: PASS");
      else
         $display("minimum_spanning_tree_kruskal_tb: FAIL");
      $finish;
   end
endmodule

FILE: sim.f
rtl/mst_pkg.sv
rtl/mst_ifs.sv
rtl/mst_ctrl.sv
rtl/mst_dp.sv
rtl/minimum_spanning_tree_kruskal.sv
test/mst_checker.sv
test/minimum_spanning_tree_kruskal_tb.sv
